/* sv/fp8bs_pkg.sv */
package fp8bs_pkg;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] block_scale;
  } in_item_t;

  typedef struct packed {
    logic [15:0] value_bf16;
    logic        domain_error;
  } out_item_t;

  localparam logic [7:0] SCALE_BAD  = 8'd255;
  localparam int         SCALE_BIAS = 127;
  localparam int         F32_BIAS   = 127;
  localparam int         F32_MIN_EXP = -126;
  localparam int         F32_SUB_SHIFT = 149;

  // decoded element after stage one
  typedef struct packed {
    logic              err;
    logic              sign;
    logic              zero;
    logic [3:0]        sig;
    logic [1:0]        n;
    logic signed [10:0] e;
    logic signed [10:0] pow2;
  } dec_t;

endpackage

/* sv/fp8bs_decode.sv */
module fp8bs_decode (
  input  fp8bs_pkg::in_item_t item,
  output fp8bs_pkg::dec_t     dec
);

  logic [3:0]         ex;
  logic [2:0]         man;
  logic [3:0]         sig;
  logic signed [10:0] pow2;
  logic [1:0]         n;

  always_comb begin
    ex  = item.code[6:3];
    man = item.code[2:0];
    if (ex != 4'd0) begin
      sig  = {1'b1, man};
      pow2 = $signed({7'd0, ex}) - 11'sd10;
    end else begin
      sig  = {1'b0, man};
      pow2 = -11'sd9;
    end
    pow2 = pow2 + $signed({3'd0, item.block_scale}) - 11'(fp8bs_pkg::SCALE_BIAS);
    if (sig[3])      n = 2'd3;
    else if (sig[2]) n = 2'd2;
    else if (sig[1]) n = 2'd1;
    else             n = 2'd0;
    dec.err  = (item.code[6:0] == 7'h7f) || (item.block_scale == fp8bs_pkg::SCALE_BAD);
    dec.sign = item.code[7];
    dec.zero = (sig == 4'd0);
    dec.sig  = sig;
    dec.n    = n;
    dec.pow2 = pow2;
    dec.e    = pow2 + $signed({9'd0, n});
  end

endmodule

/* sv/fp8bs_pack.sv */
module fp8bs_pack (
  input  fp8bs_pkg::dec_t dec,
  output logic [31:0]     bits,
  output logic            err
);

  logic [3:0]  frac4;
  logic [22:0] frac;
  logic [7:0]  bexp;
  logic [30:0] mag;
  logic [10:0] sh;

  always_comb begin
    frac4 = dec.sig & ~(4'd1 << dec.n);
    frac  = {frac4[2:0], 20'd0} << (2'd3 - dec.n);
    bexp  = 8'(dec.e + 11'(fp8bs_pkg::F32_BIAS));
    sh    = 11'(dec.pow2 + 11'(fp8bs_pkg::F32_SUB_SHIFT));
    mag   = '0;
    err   = dec.err;
    if (!dec.err && !dec.zero) begin
      if (dec.e > 11'(fp8bs_pkg::F32_BIAS)) begin
        err = 1'b1;
      end else if (dec.e >= 11'(fp8bs_pkg::F32_MIN_EXP)) begin
        mag = {bexp, frac};
      end else if (!sh[10] && sh < 11'd31) begin
        mag = 31'({27'd0, dec.sig} << sh[4:0]);
      end
    end
    bits = {dec.sign, mag};
  end

endmodule

/* sv/fp8bs_round.sv */
module fp8bs_round (
  input  logic [31:0]          bits,
  input  logic                 err,
  output fp8bs_pkg::out_item_t res
);

  logic [31:0] r;

  always_comb begin
    r = bits + 32'h7fff + {31'd0, bits[16]};
    res.domain_error = err || (r[30:23] == 8'hff);
    res.value_bf16   = res.domain_error ? 16'd0 : r[31:16];
  end

endmodule

/* sv/fp8_block_scaled_to_bf16.sv */
// E4M3 element with E8M0 block scale in, bfloat16 out, one item per cycle.
// in: valid/ready with payload {code, block_scale}; out: valid/ready with
// payload {value_bf16, domain_error}. Items are fully independent.
// Three register stages: decode, float32 pack, bf16 round. Throughput is
// one item a cycle while out is not stalled. Each stage advances when it
// is empty or the stage after it moves, so a stall on out holds every
// stage and in_ready drops only when all are full.
// domain_error is set for a NaN code, scale byte 255 or overflow to
// infinity; value_bf16 then reads 0. Negative zero is kept.
// Synchronous reset empties the pipeline; no item is in flight afterwards.
module fp8_block_scaled_to_bf16 (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fp8bs_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fp8bs_pkg::out_item_t out_data
);

  fp8bs_pkg::dec_t      dec_c, s1;
  logic [31:0]          bits_c, s2_bits;
  logic                 err_c, s2_err;
  fp8bs_pkg::out_item_t res_c, s3;
  logic v1, v2, v3;
  logic mv1, mv2, mv3;

  assign mv3 = !v3 || out_ready;
  assign mv2 = !v2 || mv3;
  assign mv1 = !v1 || mv2;
  assign in_ready  = mv1;
  assign out_valid = v3;
  assign out_data  = s3;

  fp8bs_decode u_dec (.item(in_data), .dec(dec_c));
  fp8bs_pack   u_pack (.dec(s1), .bits(bits_c), .err(err_c));
  fp8bs_round  u_rnd (.bits(s2_bits), .err(s2_err), .res(res_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (mv1) v1 <= in_valid;
      if (mv2) v2 <= v1;
      if (mv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) s1 <= dec_c;
    if (mv2) begin
      s2_bits <= bits_c;
      s2_err  <= err_c;
    end
    if (mv3) s3 <= res_c;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_err0: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.domain_error |-> out_data.value_bf16 == 16'd0)
    else $error("error item with nonzero value");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v1 && v2 && v3 && !out_ready)
    else $error("input stalled with room in pipeline");

endmodule
